>>> sv/ssht_pkg.sv
// ----------------------------------------------------------------------------
// ssht_pkg
// Shared types, constants and helpers for the scanline span hit test block.
// ----------------------------------------------------------------------------
package ssht_pkg;

  localparam int ROWS      = 4096;
  localparam int MAX_SPANS = 8;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int SLOT_W    = $clog2(MAX_SPANS);
  localparam int CNT_W     = $clog2(MAX_SPANS + 1);
  localparam int ADDR_W    = ROW_W + SLOT_W;
  localparam int RCNT_W    = 13;
  localparam int ORG_W     = 16;
  localparam int COORD_W   = 17;
  localparam int RAD_W     = 12;
  localparam int WIDE_W    = 19;
  localparam int BND_W     = 2 * COORD_W;
  localparam int CFG_W     = 16;

  localparam logic [ORG_W-1:0] ORIGIN_RESET = 16'd36000;

  // d = r * DIAG_NUM / SCALE, quotient by reciprocal multiply and one fixup
  localparam int P_W         = 25;
  localparam int T_W         = 38;
  localparam int Q_W         = 12;
  localparam int DIAG_NUM    = 7071;
  localparam int SCALE       = 10000;
  localparam int RECIP       = 6710;
  localparam int RECIP_SHIFT = 26;

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_POINT  = 2'd1,
    CMD_CIRCLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_ROW = 2'd1,
    ST_FULL   = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic {
    REG_ROW_COUNT  = 1'b0,
    REG_ROW_ORIGIN = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_APP_RD, S_APP_WR, S_MUL_P, S_MUL_Q, S_MUL_R, S_FIX,
    S_PROBE, S_CNT, S_SPAN, S_DONE
  } state_t;

  // trunc((c*SCALE + t) / SCALE) with t = +-r*DIAG_NUM = SCALE*q + m
  function automatic logic [WIDE_W-1:0] diag_pos(input logic [WIDE_W-1:0] c,
                                                  input logic [Q_W-1:0] q,
                                                  input logic nz);
    logic [WIDE_W-1:0] v;
    v = c + WIDE_W'(q);
    return v + WIDE_W'(v[WIDE_W-1] & nz);
  endfunction

  function automatic logic [WIDE_W-1:0] diag_neg(input logic [WIDE_W-1:0] c,
                                                  input logic [Q_W-1:0] q,
                                                  input logic nz);
    logic [WIDE_W-1:0] v;
    v = c - WIDE_W'(q) - WIDE_W'(nz);
    return v + WIDE_W'(v[WIDE_W-1] & nz);
  endfunction

endpackage

>>> sv/ssht_if.sv
// ----------------------------------------------------------------------------
// ssht channel interfaces
// Request, response and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ssht_req_if import ssht_pkg::*; ;
  logic                      valid;
  logic                      ready;
  logic [1:0]                command;
  logic [ROW_W-1:0]          row;
  logic signed [COORD_W-1:0] span_start;
  logic signed [COORD_W-1:0] span_end;
  logic signed [COORD_W-1:0] query_x;
  logic signed [COORD_W-1:0] query_y;
  logic [RAD_W-1:0]          radius;
  modport source (output valid, command, row, span_start, span_end, query_x, query_y,
                  radius, input ready);
  modport sink (input valid, command, row, span_start, span_end, query_x, query_y,
                radius, output ready);
endinterface

interface ssht_rsp_if;
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] status;
  modport source (output valid, hit, status, input ready);
  modport sink (input valid, hit, status, output ready);
endinterface

interface ssht_cfg_if import ssht_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             index;
  logic [CFG_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> sv/ssht_ram.sv
// ----------------------------------------------------------------------------
// ssht_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ssht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/scanline_span_hit_test.sv
// ----------------------------------------------------------------------------
// scanline_span_hit_test
// Per-row span table with append, point and eight-probe circle hit tests.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   cfg     | in  | index (row_count, row_origin), data
//   req     | in  | command, row, span_start, span_end, query_x, query_y, radius
//   rsp     | out | hit, status
//
// After reset the span-count memory is swept to zero, one row a cycle, with
// req.ready low. Append reads the row's span count, then writes the span and
// the new count, then hands off. A probe is a count read then one span-memory
// read per stored span; a circle query first does its offset math in S_MUL_P,
// S_MUL_Q, S_MUL_R and S_FIX, then up to 8 probes. A finished result waits in
// the output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module scanline_span_hit_test import ssht_pkg::*; (
  input logic        clk,
  input logic        rst,
  ssht_cfg_if.sink   cfg,
  ssht_req_if.sink   req,
  ssht_rsp_if.source rsp
);

  state_t state, state_next;

  logic [RCNT_W-1:0]  row_count;
  logic [ORG_W-1:0]   row_origin;
  logic [ROW_W-1:0]   clr_addr;
  cmd_t               cmd;
  logic [ROW_W-1:0]   app_row;
  logic [COORD_W-1:0] app_lo, app_hi, qx, qy;
  logic [RAD_W-1:0]   rad;
  logic [P_W-1:0]     prod_p, prod_q, m0;
  logic [T_W-1:0]     prod_t;
  logic [Q_W-1:0]     q0, dq;
  logic               dnz;
  logic [2:0]         pidx;
  logic [CNT_W-1:0]   nspan;
  logic [SLOT_W-1:0]  kidx;
  logic               res_hit;
  status_t            res_status;

  logic [WIDE_W-1:0]  xw, yw, rw, px, py, prow;
  logic               in_table, span_hit, last_span, last_probe, app_in, full;
  logic [WIDE_W-1:0]  lo_w, hi_w;

  logic               cnt_we;
  logic [ROW_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]   cnt_wdata, cnt_rdata;
  logic               bnd_we;
  logic [ADDR_W-1:0]  bnd_waddr, bnd_raddr;
  logic [BND_W-1:0]   bnd_wdata, bnd_rdata;
  logic [SLOT_W-1:0]  rd_slot;

  ssht_ram #(.WIDTH(CNT_W), .DEPTH(ROWS)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  ssht_ram #(.WIDTH(BND_W), .DEPTH(ROWS * MAX_SPANS)) u_bnd_ram (
    .clk(clk), .we(bnd_we), .waddr(bnd_waddr), .wdata(bnd_wdata),
    .raddr(bnd_raddr), .rdata(bnd_rdata)
  );

  // probe geometry, span and append checks, quotient fixup terms
  always_comb begin
    xw = {{(WIDE_W-COORD_W){qx[COORD_W-1]}}, qx};
    yw = {{(WIDE_W-COORD_W){qy[COORD_W-1]}}, qy};
    rw = WIDE_W'(rad);
    px = xw;
    py = yw;
    unique case (pidx)
      3'd0: py = yw + rw;
      3'd1: py = yw - rw;
      3'd2: px = xw - rw;
      3'd3: px = xw + rw;
      3'd4: begin px = diag_pos(xw, dq, dnz); py = diag_pos(yw, dq, dnz); end
      3'd5: begin px = diag_pos(xw, dq, dnz); py = diag_neg(yw, dq, dnz); end
      3'd6: begin px = diag_neg(xw, dq, dnz); py = diag_pos(yw, dq, dnz); end
      default: begin px = diag_neg(xw, dq, dnz); py = diag_neg(yw, dq, dnz); end
    endcase
    prow     = WIDE_W'(row_origin) - py;
    in_table = !prow[WIDE_W-1] && (prow[WIDE_W-2:ROW_W] == '0) &&
               (RCNT_W'(prow[ROW_W-1:0]) < row_count);
    lo_w     = {{(WIDE_W-COORD_W){bnd_rdata[BND_W-1]}}, bnd_rdata[BND_W-1:COORD_W]};
    hi_w     = {{(WIDE_W-COORD_W){bnd_rdata[COORD_W-1]}}, bnd_rdata[COORD_W-1:0]};
    span_hit = ($signed(lo_w) <= $signed(px)) && ($signed(hi_w) >= $signed(px));
    last_span  = (CNT_W'(kidx) + CNT_W'(1)) == nspan;
    last_probe = (pidx == 3'd7) || (cmd == CMD_POINT);
    app_in     = RCNT_W'(app_row) < row_count;
    full       = cnt_rdata >= CNT_W'(MAX_SPANS);
    q0         = prod_t[RECIP_SHIFT +: Q_W];
    m0         = prod_p - prod_q;
  end

  // next state and memory controls
  always_comb begin
    state_next = state;
    req.ready  = (state == S_IDLE);
    cfg.ready  = 1'b1;
    rd_slot    = (state == S_SPAN) ? kidx + SLOT_W'(1) : '0;
    cnt_raddr  = (state == S_APP_RD) ? app_row : prow[ROW_W-1:0];
    bnd_raddr  = {prow[ROW_W-1:0], rd_slot};
    cnt_we     = 1'b0;
    cnt_waddr  = app_row;
    cnt_wdata  = cnt_rdata + CNT_W'(1);
    bnd_we     = 1'b0;
    bnd_waddr  = {app_row, cnt_rdata[SLOT_W-1:0]};
    bnd_wdata  = {app_lo, app_hi};
    unique case (state)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
        if (clr_addr == ROW_W'(ROWS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          unique case (cmd_t'(req.command))
            CMD_APPEND: state_next = S_APP_RD;
            CMD_POINT:  state_next = S_PROBE;
            CMD_CIRCLE: state_next = S_MUL_P;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_APP_RD: state_next = app_in ? S_APP_WR : S_DONE;
      S_APP_WR: begin
        cnt_we     = !full;
        bnd_we     = !full;
        state_next = S_DONE;
      end
      S_MUL_P: state_next = S_MUL_Q;
      S_MUL_Q: state_next = S_MUL_R;
      S_MUL_R: state_next = S_FIX;
      S_FIX:   state_next = S_PROBE;
      S_PROBE: state_next = in_table ? S_CNT : S_DONE;
      S_CNT: begin
        if (cnt_rdata != '0) state_next = S_SPAN;
        else                 state_next = last_probe ? S_DONE : S_PROBE;
      end
      S_SPAN: begin
        if (span_hit)       state_next = S_DONE;
        else if (last_span) state_next = last_probe ? S_DONE : S_PROBE;
      end
      S_DONE: if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // config, clear sweep, output register
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count  <= '0;
      row_origin <= ORIGIN_RESET;
      clr_addr   <= '0;
      rsp.valid  <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (reg_idx_t'(cfg.index))
          REG_ROW_COUNT:  row_count  <= cfg.data[RCNT_W-1:0];
          default:        row_origin <= cfg.data[ORG_W-1:0];
        endcase
      end
      if (state == S_CLEAR) clr_addr <= clr_addr + ROW_W'(1);
      if (state == S_DONE && (!rsp.valid || rsp.ready)) rsp.valid <= 1'b1;
      else if (rsp.valid && rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.hit    <= res_hit;
      rsp.status <= res_status;
    end
    unique case (state)
      S_IDLE: begin
        cmd        <= cmd_t'(req.command);
        app_row    <= req.row;
        app_lo     <= req.span_start;
        app_hi     <= req.span_end;
        qx         <= req.query_x;
        qy         <= req.query_y;
        rad        <= (cmd_t'(req.command) == CMD_CIRCLE) ? req.radius : '0;
        pidx       <= '0;
        res_hit    <= 1'b0;
        res_status <= ST_OK;
      end
      S_APP_RD: if (!app_in) res_status <= ST_NO_ROW;
      S_APP_WR: if (full) res_status <= ST_FULL;
      S_MUL_P:  prod_p <= P_W'(rad) * P_W'(DIAG_NUM);
      S_MUL_Q:  prod_t <= T_W'(prod_p) * T_W'(RECIP);
      S_MUL_R:  prod_q <= P_W'(q0) * P_W'(SCALE);
      S_FIX: begin
        // quotient estimate may be one short
        if (m0 >= P_W'(SCALE)) begin
          dq  <= q0 + Q_W'(1);
          dnz <= (m0 != P_W'(SCALE));
        end else begin
          dq  <= q0;
          dnz <= (m0 != '0);
        end
      end
      S_PROBE: if (!in_table) res_hit <= 1'b1;
      S_CNT: begin
        nspan <= cnt_rdata;
        kidx  <= '0;
        if (cnt_rdata == '0) pidx <= pidx + 3'd1;
      end
      S_SPAN: begin
        if (span_hit) res_hit <= 1'b1;
        else if (last_span) pidx <= pidx + 3'd1;
        kidx <= kidx + SLOT_W'(1);
      end
      default: ;
    endcase
  end

endmodule

>>> tb/tb_scoreboard.sv
// ----------------------------------------------------------------------------
// Span hit scoreboard
// Mirrors the span table and the two registers, works out the hit and status
// expected for each accepted transaction and checks results in order.
// ----------------------------------------------------------------------------
package tb_scoreboard_pkg;
  import ssht_pkg::*;

  typedef struct packed {
    logic       hit;
    logic [1:0] status;
  } span_result_t;

  class span_scoreboard;
    int unsigned   table_count;
    int unsigned   origin;
    int unsigned   row_spans[ROWS];
    int            lo_bound[ROWS * MAX_SPANS];
    int            hi_bound[ROWS * MAX_SPANS];
    span_result_t  pending[$];
    int            mismatches;
    int            checked;
    int            appends_ok;
    int            appends_dropped;
    int            query_hits;

    function new();
      table_count = 0;
      origin = ORIGIN_RESET;
      foreach (row_spans[i]) row_spans[i] = 0;
      mismatches = 0;
      checked = 0;
      appends_ok = 0;
      appends_dropped = 0;
      query_hits = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx == REG_ROW_COUNT) table_count = value[RCNT_W-1:0];
      else origin = value;
    endfunction

    function int unsigned rows_in_use();
      return (table_count < ROWS) ? table_count : ROWS;
    endfunction

    function bit probe_hit(longint x, longint y);
      longint r;
      int unsigned base;
      r = longint'(origin) - y;
      if (r < 0 || r >= rows_in_use()) return 1;
      base = r * MAX_SPANS;
      for (int k = 0; k < row_spans[r]; k++)
        if (lo_bound[base + k] <= x && hi_bound[base + k] >= x) return 1;
      return 0;
    endfunction

    // SV integer division truncates toward zero
    function longint diag_coord(longint c, longint r, int sgn);
      return (c * 10000 + sgn * r * 7071) / 10000;
    endfunction

    function bit circle_hit(longint x, longint y, longint r);
      if (probe_hit(x, y + r) || probe_hit(x, y - r) ||
          probe_hit(x - r, y) || probe_hit(x + r, y)) return 1;
      for (int sx = 1; sx >= -1; sx -= 2)
        for (int sy = 1; sy >= -1; sy -= 2)
          if (probe_hit(diag_coord(x, r, sx), diag_coord(y, r, sy))) return 1;
      return 0;
    endfunction

    function void note_request(cmd_t cmd, logic [ROW_W-1:0] row,
                               logic signed [COORD_W-1:0] s0,
                               logic signed [COORD_W-1:0] s1,
                               logic signed [COORD_W-1:0] qx,
                               logic signed [COORD_W-1:0] qy,
                               logic [RAD_W-1:0] rad);
      span_result_t res;
      res = '0;
      case (cmd)
        CMD_APPEND: begin
          if (row >= rows_in_use()) begin
            res.status = ST_NO_ROW;
            appends_dropped++;
          end else if (row_spans[row] >= MAX_SPANS) begin
            res.status = ST_FULL;
            appends_dropped++;
          end else begin
            lo_bound[row * MAX_SPANS + row_spans[row]] = s0;
            hi_bound[row * MAX_SPANS + row_spans[row]] = s1;
            row_spans[row]++;
            res.status = ST_OK;
            appends_ok++;
          end
        end
        CMD_POINT:  res.hit = probe_hit(qx, qy);
        CMD_CIRCLE: res.hit = circle_hit(qx, qy, rad);
        default: ;
      endcase
      if (res.hit) query_hits++;
      pending.push_back(res);
    endfunction

    function void check_result(logic hit, logic [1:0] status);
      span_result_t want;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result hit=%0d status=%0d with nothing pending", hit, status);
        return;
      end
      want = pending.pop_front();
      if (hit !== want.hit || status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: expected hit=%0d status=%0d, got hit=%0d status=%0d",
                   checked, want.hit, want.status, hit, status);
      end
    endfunction
  endclass
endpackage

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Scanline span hit test bench
// Builds span tables through append transactions, then fires point and
// circle queries around them under random gaps, stalls and register changes.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssht_pkg::*;
  import tb_scoreboard_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssht_cfg_if cfg ();
  ssht_req_if req ();
  ssht_rsp_if rsp ();

  scanline_span_hit_test dut (.clk(clk), .rst(rst), .cfg(cfg), .req(req), .rsp(rsp));

  span_scoreboard sb = new();

  int  hold_off_cycles = 0;   // long receiver stall, counted at the sink
  bit  drain_on = 0;
  int  sent = 0;
  int  points = 0;
  int  circles = 0;
  int  settings = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cfg.valid = 1'b0;
    cfg.index = REG_ROW_COUNT;
    cfg.data  = '0;
    req.valid = 1'b0;
    req.command = CMD_NONE;
    req.row = '0;
    req.span_start = '0;
    req.span_end = '0;
    req.query_x = '0;
    req.query_y = '0;
    req.radius = '0;
    rsp.ready = 1'b0;
  end

  // monitor: sample at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready)
        sb.note_request(cmd_t'(req.command), req.row, req.span_start, req.span_end,
                        req.query_x, req.query_y, req.radius);
      if (rsp.valid && rsp.ready) sb.check_result(rsp.hit, rsp.status);
      if (cfg.valid && cfg.ready) sb.write_reg(reg_idx_t'(cfg.index), cfg.data);
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // response sink: random stalls plus the requested long hold-off
  always @(negedge clk) begin
    if (rst) rsp.ready <= 1'b0;
    else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      rsp.ready <= 1'b0;
    end else if (drain_on) rsp.ready <= 1'b1;
    else rsp.ready <= ($urandom_range(0, 99) < 70);
  end

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic send(cmd_t cmd, int row, int s0, int s1, int qx, int qy, int rad,
                      bit gaps = 1);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      @(negedge clk);
      req.valid <= 1'b0;
      repeat (g - 1) @(negedge clk);
    end
    @(negedge clk);
    req.valid <= 1'b1;
    req.command <= cmd;
    req.row <= row[ROW_W-1:0];
    req.span_start <= s0[COORD_W-1:0];
    req.span_end <= s1[COORD_W-1:0];
    req.query_x <= qx[COORD_W-1:0];
    req.query_y <= qy[COORD_W-1:0];
    req.radius <= rad[RAD_W-1:0];
    do @(posedge clk); while (!req.ready);
    sent++;
    if (cmd == CMD_POINT) points++;
    if (cmd == CMD_CIRCLE) circles++;
  endtask

  task automatic idle_req();
    @(negedge clk);
    req.valid <= 1'b0;
  endtask

  // wait for every pending result, then let the block settle
  task automatic drain();
    idle_req();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 5))
      0: return -65536;
      1: return 65535;
      2: return $urandom_range(0, 131071) - 65536;
      default: return $urandom_range(0, 200) - 100;
    endcase
  endfunction

  // y that lands near the populated rows
  function automatic int row_y(int rows);
    int r;
    r = $urandom_range(0, rows + 1) - 1;
    return int'(sb.origin) - r;
  endfunction

  task automatic random_phase(int n, int rows);
    int c, r, s, x, y, rad;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      rad = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 12);
      if (c < 40) begin
        r = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                          : $urandom_range(0, rows + 1);
        s = $urandom_range(0, 9) == 0 ? rand_coord() : $urandom_range(0, 200) - 100;
        send(CMD_APPEND, r, s, s + $urandom_range(0, 40) - 5, 0, 0, rad);
      end else if (c < 70) begin
        x = $urandom_range(0, 9) == 0 ? rand_coord() : $urandom_range(0, 200) - 100;
        y = $urandom_range(0, 9) == 0 ? rand_coord() : row_y(rows);
        send(CMD_POINT, $urandom_range(0, 4095), rand_coord(), rand_coord(), x, y, rad);
      end else if (c < 97) begin
        x = $urandom_range(0, 9) == 0 ? rand_coord() : $urandom_range(0, 200) - 100;
        y = $urandom_range(0, 9) == 0 ? rand_coord() : row_y(rows);
        send(CMD_CIRCLE, $urandom_range(0, 4095), 0, 0, x, y, rad);
      end else begin
        send(CMD_NONE, $urandom_range(0, 4095), rand_coord(), rand_coord(),
             rand_coord(), rand_coord(), $urandom_range(0, 4095));
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: registers at reset, then a small table with its origin at 100
    send(CMD_APPEND, 0, 0, 5, 0, 0, 0, 0);             // table empty: dropped
    send(CMD_POINT, 0, 0, 0, 0, 0, 0, 0);               // out of table: hit
    send(CMD_NONE, 4095, -65536, 65535, -65536, 65535, 4095, 0);
    drain();
    write_reg(REG_ROW_COUNT, 16'd4);
    write_reg(REG_ROW_ORIGIN, 16'd100);
    settings++;
    send(CMD_APPEND, 0, -65536, 65535, 0, 0, 0, 0);
    send(CMD_APPEND, 1, 10, 20, 0, 0, 0, 0);
    send(CMD_APPEND, 1, 30, 25, 0, 0, 0, 0);            // reversed span
    send(CMD_APPEND, 4, 0, 1, 0, 0, 0, 0);              // past the table
    send(CMD_APPEND, 4095, 0, 1, 0, 0, 0, 0);
    for (int k = 0; k < 9; k++)                          // fill row 2, then overflow
      send(CMD_APPEND, 2, k * 10, k * 10 + 3, 0, 0, 0, 0);
    send(CMD_POINT, 0, 0, 0, 15, 99, 0, 0);
    send(CMD_POINT, 0, 0, 0, 27, 99, 0, 0);
    send(CMD_POINT, 0, 0, 0, 9, 99, 0, 0);
    send(CMD_POINT, 0, 0, 0, 0, 101, 0, 0);             // row below zero
    send(CMD_POINT, 0, 0, 0, 65535, -65536, 0, 0);
    send(CMD_CIRCLE, 0, 0, 0, 50, 98, 0, 0);
    send(CMD_CIRCLE, 0, 0, 0, 15, 98, 7, 0);
    send(CMD_CIRCLE, 0, 0, 0, -65536, 65535, 4095, 0);
    drain();

    // long receiver stall while requests keep coming
    hold_off_cycles = 300;
    for (int k = 0; k < 20; k++) send(CMD_POINT, 0, 0, 0, k, 99, 0, 0);
    drain();

    // shrink the table, spans stay; then grow it back
    write_reg(REG_ROW_COUNT, 16'd0);
    random_phase(20, 4);
    drain();
    write_reg(REG_ROW_COUNT, 16'd4096);
    write_reg(REG_ROW_ORIGIN, 16'd0);
    settings++;
    random_phase(60, 6);
    drain();
    write_reg(REG_ROW_COUNT, 16'h1FFF);
    write_reg(REG_ROW_ORIGIN, 16'hFFFF);
    settings++;
    send(CMD_APPEND, 4095, -3, 3, 0, 0, 0);
    send(CMD_POINT, 0, 0, 0, 0, 65535 - 4095, 0);
    send(CMD_CIRCLE, 0, 0, 0, 0, 65535 - 4090, 5);
    random_phase(60, 8);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_ROW_COUNT, 16'($urandom_range(4, 24)));
      write_reg(REG_ROW_ORIGIN, 16'($urandom_range(0, 65535)));
      settings++;
      random_phase(120, 24);
      if (ph == 3) hold_off_cycles = 200;
      drain();
    end

    // final drain with the sink kept ready
    drain_on = 1;
    drain();
    $display("Covered %0d transactions (%0d point, %0d circle queries, %0d hits) over %0d settings",
             sent, points, circles, sb.query_hits, settings);
    $display("Appends stored %0d, dropped %0d; results checked %0d, mismatches %0d",
             sb.appends_ok, sb.appends_dropped, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

>>> sim.f
sv/ssht_pkg.sv
sv/ssht_if.sv
sv/ssht_ram.sv
sv/scanline_span_hit_test.sv
tb/tb_scoreboard.sv
tb/tb_top.sv
